### hdl/tilt_compensated_heading_macros.svh
// Assertion macros shared by the heading checker.
`ifndef TILT_COMPENSATED_HEADING_MACROS_SVH
`define TILT_COMPENSATED_HEADING_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define THC_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heading check failed");

// The consequent must hold in the cycle after the antecedent.
`define THC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heading check failed");

`endif

### hdl/thc_pkg.sv
// Shared constants, types and functions of the tilt-compensated heading pipeline.
package thc_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int FRACTION_BITS = 6;
    localparam int HEADING_BITS  = FRACTION_BITS + 9;
    localparam int TABLE_LEN     = 24;
    localparam int SCALE_SHIFT   = 32 - SAMPLE_BITS;
    localparam int W             = 36;
    localparam int AW            = 34;
    localparam int UW            = W + 25;
    localparam int INV_GAIN      = 10188014;
    localparam int HEAD_LIM      = 180 << FRACTION_BITS;

    localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    typedef struct packed {
        logic                 zero;
        logic signed [W-1:0]  ax;
        logic signed [W-1:0]  ay;
        logic signed [W-1:0]  az;
        logic signed [W-1:0]  syz;
        logic signed [W-1:0]  sxz;
        logic signed [AW-1:0] pitch;
        logic signed [AW-1:0] roll;
        logic signed [W-1:0]  x2;
        logic signed [W-1:0]  w;
        logic signed [W-1:0]  y2;
    } side_t;

    function automatic logic signed [W-1:0] ungain(input logic signed [W-1:0] v);
        logic signed [UW-1:0] p;
        p = UW'(v) * UW'(INV_GAIN) + UW'(1 << 23);
        return W'(p >>> 24);
    endfunction

endpackage

### hdl/thc_cordic.sv
// Pipelined CORDIC, one register stage per iteration, in vectoring or rotation mode.
module thc_cordic (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          rotate,
    input  logic                          in_valid,
    input  logic signed [thc_pkg::W-1:0]  in_x,
    input  logic signed [thc_pkg::W-1:0]  in_y,
    input  logic signed [thc_pkg::AW-1:0] in_z,
    input  thc_pkg::side_t                in_side,
    output logic                          out_valid,
    output logic signed [thc_pkg::W-1:0]  out_x,
    output logic signed [thc_pkg::W-1:0]  out_y,
    output logic signed [thc_pkg::AW-1:0] out_z,
    output thc_pkg::side_t                out_side
);
    import thc_pkg::*;

    logic [CORDIC_STAGES-1:0] v_reg;
    logic signed [W-1:0]      x_reg    [CORDIC_STAGES];
    logic signed [W-1:0]      y_reg    [CORDIC_STAGES];
    logic signed [AW-1:0]     z_reg    [CORDIC_STAGES];
    side_t                    side_reg [CORDIC_STAGES];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        logic                 vi;
        logic signed [W-1:0]  xi;
        logic signed [W-1:0]  yi;
        logic signed [AW-1:0] zi;
        side_t                si;
        logic                 down;
        logic signed [AW-1:0] t;
        logic signed [W-1:0]  x_next;
        logic signed [W-1:0]  y_next;
        logic signed [AW-1:0] z_next;

        if (i == 0) begin : g_first
            assign vi = in_valid;
            assign xi = in_x;
            assign yi = in_y;
            assign zi = in_z;
            assign si = in_side;
        end else begin : g_rest
            assign vi = v_reg[i-1];
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
            assign si = side_reg[i-1];
        end

        assign t    = $signed(AW'(ATAN_TAB[i]));
        assign down = rotate ? (zi >= 0) : (yi < 0);

        always_comb begin
            if (down) begin
                x_next = xi - (yi >>> i);
                y_next = yi + (xi >>> i);
                z_next = zi - t;
            end else begin
                x_next = xi + (yi >>> i);
                y_next = yi - (xi >>> i);
                z_next = zi + t;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= vi;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i]    <= x_next;
                y_reg[i]    <= y_next;
                z_reg[i]    <= z_next;
                side_reg[i] <= si;
            end
        end
    end

    assign out_valid = v_reg[CORDIC_STAGES-1];
    assign out_x     = x_reg[CORDIC_STAGES-1];
    assign out_y     = y_reg[CORDIC_STAGES-1];
    assign out_z     = z_reg[CORDIC_STAGES-1];
    assign out_side  = side_reg[CORDIC_STAGES-1];

endmodule

### hdl/thc_ungain.sv
// Registered CORDIC gain removal for two values.
module thc_ungain (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [thc_pkg::W-1:0] in_a,
    input  logic signed [thc_pkg::W-1:0] in_b,
    input  thc_pkg::side_t               in_side,
    output logic                         out_valid,
    output logic signed [thc_pkg::W-1:0] out_a,
    output logic signed [thc_pkg::W-1:0] out_b,
    output thc_pkg::side_t               out_side
);
    import thc_pkg::*;

    logic                v_reg;
    logic signed [W-1:0] a_reg;
    logic signed [W-1:0] b_reg;
    side_t               side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg    <= ungain(in_a);
            b_reg    <= ungain(in_b);
            side_reg <= in_side;
        end
    end

    assign out_valid = v_reg;
    assign out_a     = a_reg;
    assign out_b     = b_reg;
    assign out_side  = side_reg;

endmodule

### hdl/tilt_compensated_heading.sv
// Top level of the tilt-compensated compass heading pipeline.
//
// The input channel (s_valid, s_ready, s_mag_x, s_mag_y, s_mag_z) takes one
// signed three-axis magnetometer sample per transfer. The result channel
// (m_valid, m_ready, m_heading_deg) returns one heading per sample, in
// degrees with FRACTION_BITS fraction bits, in the order of the samples.
// The work runs through seven CORDIC passes of CORDIC_STAGES iterations,
// one register stage each, four gain-removal multiplier stages, an input
// register, a degree conversion multiplier and the output register.
// Throughput is one sample per cycle while the receiver does not stall.
// A synchronous active-low reset clears all valid bits; no sample is in
// flight afterwards. When the receiver stalls with a result waiting, the
// whole pipeline holds and s_ready falls; nothing is lost or repeated.
// An all-zero input sample, or another that the input zero test flags, gives heading 0.
module tilt_compensated_heading (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [thc_pkg::SAMPLE_BITS-1:0]  s_mag_x,
    input  logic signed [thc_pkg::SAMPLE_BITS-1:0]  s_mag_y,
    input  logic signed [thc_pkg::SAMPLE_BITS-1:0]  s_mag_z,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [thc_pkg::HEADING_BITS-1:0] m_heading_deg
);
    import thc_pkg::*;

    localparam int PW = AW + HEADING_BITS;

    logic m_valid_reg;
    logic en;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    logic                v0_reg;
    side_t               side0_reg;
    side_t               side0_next;
    logic signed [W-1:0] ex;
    logic signed [W-1:0] ey;
    logic signed [W-1:0] ez;

    assign ex = W'(s_mag_x) <<< SCALE_SHIFT;
    assign ey = W'(s_mag_y) <<< SCALE_SHIFT;
    assign ez = W'(s_mag_z) <<< SCALE_SHIFT;

    always_comb begin
        side0_next      = '0;
        side0_next.ax   = ex;
        side0_next.ay   = ey;
        side0_next.az   = ez;
        side0_next.zero = ((s_mag_x == 0) && ((s_mag_y == 0) || (s_mag_z >= 0)))
                       || ((s_mag_y == 0) && (s_mag_z >= 0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side0_reg <= side0_next;
        end
    end

    logic                c1_v, u1_v, c2_v, u2_v, c3_v, c4_v, c5_v, u3_v, c6_v, u4_v, c7_v;
    logic signed [W-1:0] c1_x, u1_a, c2_x, u2_a, c5_x, c5_y, u3_a, u3_b, c6_x, u4_a;
    logic signed [AW-1:0] c3_z, c4_z, c7_z;
    side_t c1_s, u1_s, side1, c2_s, u2_s, side2, c3_s, side3, c4_s, side4;
    side_t c5_s, u3_s, side5, c6_s, u4_s, side6, c7_s;
    logic signed [W-1:0] ay_abs, ax_abs, v5_x, v5_y;

    assign ay_abs = side0_reg.ay < 0 ? -side0_reg.ay : side0_reg.ay;

    thc_cordic u_c1 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .rotate(1'b0), .in_valid(v0_reg),
        .in_x(ay_abs), .in_y(side0_reg.az), .in_z('0), .in_side(side0_reg),
        .out_valid(c1_v), .out_x(c1_x), .out_y(), .out_z(), .out_side(c1_s)
    );

    thc_ungain u_u1 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(c1_v),
        .in_a(c1_x), .in_b('0), .in_side(c1_s),
        .out_valid(u1_v), .out_a(u1_a), .out_b(), .out_side(u1_s)
    );

    always_comb begin
        side1     = u1_s;
        side1.syz = u1_a;
    end

    assign ax_abs = side1.ax < 0 ? -side1.ax : side1.ax;

    thc_cordic u_c2 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .rotate(1'b0), .in_valid(u1_v),
        .in_x(ax_abs), .in_y(side1.az), .in_z('0), .in_side(side1),
        .out_valid(c2_v), .out_x(c2_x), .out_y(), .out_z(), .out_side(c2_s)
    );

    thc_ungain u_u2 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(c2_v),
        .in_a(c2_x), .in_b('0), .in_side(c2_s),
        .out_valid(u2_v), .out_a(u2_a), .out_b(), .out_side(u2_s)
    );

    always_comb begin
        side2     = u2_s;
        side2.sxz = u2_a;
    end

    thc_cordic u_c3 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .rotate(1'b0), .in_valid(u2_v),
        .in_x(side2.syz), .in_y(side2.ax), .in_z('0), .in_side(side2),
        .out_valid(c3_v), .out_x(), .out_y(), .out_z(c3_z), .out_side(c3_s)
    );

    always_comb begin
        side3       = c3_s;
        side3.pitch = c3_z;
    end

    thc_cordic u_c4 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .rotate(1'b0), .in_valid(c3_v),
        .in_x(side3.sxz), .in_y(side3.ay), .in_z('0), .in_side(side3),
        .out_valid(c4_v), .out_x(), .out_y(), .out_z(c4_z), .out_side(c4_s)
    );

    always_comb begin
        side4      = c4_s;
        side4.roll = c4_z;
    end

    thc_cordic u_c5 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .rotate(1'b1), .in_valid(c4_v),
        .in_x(side4.ax), .in_y(side4.az), .in_z(side4.pitch), .in_side(side4),
        .out_valid(c5_v), .out_x(c5_x), .out_y(c5_y), .out_z(), .out_side(c5_s)
    );

    thc_ungain u_u3 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(c5_v),
        .in_a(c5_x), .in_b(c5_y), .in_side(c5_s),
        .out_valid(u3_v), .out_a(u3_a), .out_b(u3_b), .out_side(u3_s)
    );

    always_comb begin
        side5    = u3_s;
        side5.x2 = u3_a;
        side5.w  = u3_b;
    end

    thc_cordic u_c6 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .rotate(1'b1), .in_valid(u3_v),
        .in_x(side5.ay), .in_y(side5.w), .in_z(side5.roll), .in_side(side5),
        .out_valid(c6_v), .out_x(c6_x), .out_y(), .out_z(), .out_side(c6_s)
    );

    thc_ungain u_u4 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(c6_v),
        .in_a(c6_x), .in_b('0), .in_side(c6_s),
        .out_valid(u4_v), .out_a(u4_a), .out_b(), .out_side(u4_s)
    );

    always_comb begin
        side6    = u4_s;
        side6.y2 = u4_a;
    end

    assign v5_x = side6.y2 < 0 ? -side6.y2 : side6.y2;
    assign v5_y = side6.y2 < 0 ? -side6.x2 : side6.x2;

    thc_cordic u_c7 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .rotate(1'b0), .in_valid(u4_v),
        .in_x(v5_x), .in_y(v5_y), .in_z('0), .in_side(side6),
        .out_valid(c7_v), .out_x(), .out_y(), .out_z(c7_z), .out_side(c7_s)
    );

    // The half turn is added when the rotated vector points backwards.
    logic signed [AW-1:0] ang_base;
    logic signed [AW-1:0] ang_sum;
    logic                 vc_reg;
    logic                 zc_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;

    always_comb begin
        if (c7_s.y2 < 0) begin
            ang_base = (c7_s.x2 >= 0) ? (AW'(1) <<< 31) : -(AW'(1) <<< 31);
        end else begin
            ang_base = '0;
        end
        ang_sum   = c7_z + ang_base;
        prod_next = PW'(ang_sum) * PW'(HEAD_LIM);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else if (en) begin
            vc_reg <= c7_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            zc_reg   <= c7_s.zero;
        end
    end

    logic signed [PW-1:0]           deg_full;
    logic signed [HEADING_BITS-1:0] heading_next;
    logic signed [HEADING_BITS-1:0] heading_reg;

    assign deg_full = (prod_reg + (PW'(1) <<< 30)) >>> 31;

    always_comb begin
        if (zc_reg) begin
            heading_next = '0;
        end else if (deg_full > PW'(HEAD_LIM)) begin
            heading_next = HEADING_BITS'(HEAD_LIM);
        end else if (deg_full < -PW'(HEAD_LIM)) begin
            heading_next = -HEADING_BITS'(HEAD_LIM);
        end else begin
            heading_next = HEADING_BITS'(deg_full);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            heading_reg <= heading_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_heading_deg = heading_reg;

endmodule

### hdl/thc_checker.sv
// Port-level checker for the tilt-compensated heading block, with its bind.
`include "tilt_compensated_heading_macros.svh"

module thc_checker (
    input logic                                    aclk,
    input logic                                    aresetn,
    input logic                                    s_ready,
    input logic                                    m_valid,
    input logic                                    m_ready,
    input logic signed [thc_pkg::HEADING_BITS-1:0] m_heading_deg
);
    import thc_pkg::*;

    `THC_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_heading_deg))
    `THC_ASSERT_NOW(a_range, aclk, aresetn, m_valid, (m_heading_deg <= HEADING_BITS'(HEAD_LIM)) && (m_heading_deg >= -HEADING_BITS'(HEAD_LIM)))
    `THC_ASSERT_NOW(a_backpressure, aclk, aresetn, m_valid && !m_ready, !s_ready)

endmodule

bind tilt_compensated_heading thc_checker u_thc_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_heading_deg(m_heading_deg)
);
